/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/gcmt_pkg.sv */
// ----------------------------------------------------------------------------
// gcmt_pkg
// Types and constants of the G-code motion state tracker.
// ----------------------------------------------------------------------------
package gcmt_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [1:0] ACT_G = 2'd0;
   localparam logic [1:0] ACT_M = 2'd1;

   localparam logic [9:0] G_ARC_CCW    = 10'd3;
   localparam logic [9:0] G_ABSOLUTE   = 10'd90;
   localparam logic [9:0] G_RELATIVE   = 10'd91;
   localparam logic [9:0] G_SET_ORIGIN = 10'd92;

   localparam int SUM_W  = 66;  // sum of three squared 32-bit deltas
   localparam int ROOT_W = 34;  // root iterations, one bit pair each
   localparam int NUM_W  = 56;  // root * 60 * 65536
   localparam int CNT_W  = 6;

   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   // Clamp a 33-bit signed sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic [32:0] s);
      logic [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/gcmt_req_if.sv */
// ----------------------------------------------------------------------------
// gcmt_req_if
// Command channel: one parsed G-code command per item.
// ----------------------------------------------------------------------------
interface gcmt_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic        [9:0]  code;
   logic        [4:0]  present;
   logic signed [31:0] val_x;
   logic signed [31:0] val_y;
   logic signed [31:0] val_z;
   logic signed [31:0] val_e;
   logic signed [31:0] val_f;

   modport source (output valid, action, code, present, val_x, val_y, val_z, val_e,
                   val_f, input ready);
   modport sink (input valid, action, code, present, val_x, val_y, val_z, val_e,
                 val_f, output ready);
endinterface

/* rtl/gcmt_rsp_if.sv */
// ----------------------------------------------------------------------------
// gcmt_rsp_if
// Result channel: machine state after each command.
// ----------------------------------------------------------------------------
interface gcmt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] pos_e;
   logic signed [31:0] feed;
   logic        [30:0] move_distance;
   logic        [2:0]  move_flags;
   logic               new_layer;
   logic        [47:0] total_time;
   logic        [47:0] total_extruded;
   logic signed [31:0] max_retract_feed;
   logic               status;

   modport source (output valid, pos_x, pos_y, pos_z, pos_e, feed, move_distance,
                   move_flags, new_layer, total_time, total_extruded, max_retract_feed,
                   status, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, pos_e, feed, move_distance,
                 move_flags, new_layer, total_time, total_extruded, max_retract_feed,
                 status, output ready);
endinterface

/* rtl/gcode_motion_state_tracker.sv */
// ----------------------------------------------------------------------------
// gcode_motion_state_tracker
// Tracks position, feed and print totals over a stream of G-code commands.
// ----------------------------------------------------------------------------
// One command is taken at a time. Position, feed, extrusion and flags are
// updated in the cycle the item is taken; commands other than a move with a
// positive start feed go straight to the finish state, which hands the
// result to the output register once it is free. A timed move then runs
// through one 32x32 multiplier for the squared deltas, a digit-serial square
// root taking one bit pair per cycle and a bit-serial divider for the move
// time. The result sits in an output register, and the next command is
// taken while it waits there.
`include "assert_macros.svh"

module gcode_motion_state_tracker (
   input  logic          clock,
   input  logic          reset,
   gcmt_req_if.sink      req_chan,
   gcmt_rsp_if.source    rsp_chan
);

   gcmt_pkg::state_type state_ff, state_in;
   logic [gcmt_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   // architectural state
   logic [31:0] pos_ff [3];
   logic [31:0] pos_in [3];
   logic [31:0] epos_ff, epos_in, feed_ff, feed_in, lez_ff, lez_in, rmax_ff, rmax_in;
   logic        rel_ff, rel_in;
   logic [2:0]  seen_ff, seen_in;
   logic [47:0] time_sum_ff, time_sum_in, ext_sum_ff, ext_sum_in;

   // per-item work registers
   logic [31:0] mag_ff [3];
   logic [31:0] mag_in [3];
   logic [30:0] sf_ff, sf_in;
   logic [2:0]  flags_ff, flags_in;
   logic        newl_ff, newl_in, stat_ff, stat_in;
   logic [63:0] prod_ff, prod_in;
   logic [gcmt_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic [gcmt_pkg::SUM_W+1:0]  sq_ff, sq_in;
   logic [gcmt_pkg::ROOT_W+2:0] rrem_ff, rrem_in;
   logic [gcmt_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [gcmt_pkg::NUM_W-1:0]  num_ff, num_in, quo_ff, quo_in;
   logic [30:0] drem_ff, drem_in;
   logic [30:0] dist_ff, dist_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_pos_ff [4];
   logic [31:0] o_pos_in [4];
   logic [31:0] o_feed_ff, o_feed_in, o_rmax_ff, o_rmax_in;
   logic [30:0] o_dist_ff, o_dist_in;
   logic [2:0]  o_flags_ff, o_flags_in;
   logic        o_newl_ff, o_newl_in, o_stat_ff, o_stat_in;
   logic [47:0] o_time_ff, o_time_in, o_ext_ff, o_ext_in;

   // combinational helpers
   logic [31:0] vin [3];
   logic        accept;
   logic        slot_free;

   assign vin[0]    = req_chan.val_x;
   assign vin[1]    = req_chan.val_y;
   assign vin[2]    = req_chan.val_z;
   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == gcmt_pkg::ST_IDLE);

   always_comb begin
      logic [31:0] base;
      logic [32:0] psum;
      logic [32:0] delta;
      logic [32:0] sd;
      logic [48:0] esum;
      logic [31:0] sfs;
      logic [32:0] diff;
      logic [35:0] rshift;
      logic [35:0] rtest;
      logic [31:0] dshift;
      logic [56:0] tsum;
      logic [31:0] msel;

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      epos_in     = epos_ff;
      feed_in     = feed_ff;
      lez_in      = lez_ff;
      rmax_in     = rmax_ff;
      rel_in      = rel_ff;
      seen_in     = seen_ff;
      time_sum_in = time_sum_ff;
      ext_sum_in  = ext_sum_ff;
      mag_in      = mag_ff;
      sf_in       = sf_ff;
      flags_in    = flags_ff;
      newl_in     = newl_ff;
      stat_in     = stat_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      rrem_in     = rrem_ff;
      root_in     = root_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      drem_in     = drem_ff;
      dist_in     = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      o_pos_in    = o_pos_ff;
      o_feed_in   = o_feed_ff;
      o_rmax_in   = o_rmax_ff;
      o_dist_in   = o_dist_ff;
      o_flags_in  = o_flags_ff;
      o_newl_in   = o_newl_ff;
      o_stat_in   = o_stat_ff;
      o_time_in   = o_time_ff;
      o_ext_in    = o_ext_ff;
      base = '0; psum = '0; delta = '0; sd = '0; esum = '0; sfs = '0; diff = '0;
      rshift = '0; rtest = '0; dshift = '0; tsum = '0; msel = '0;

      case (state_ff)
         gcmt_pkg::ST_IDLE: begin
            if (accept) begin
               flags_in = '0;
               newl_in  = 1'b0;
               stat_in  = 1'b0;
               dist_in  = '0;
               state_in = gcmt_pkg::ST_FINISH;
               if (req_chan.action == gcmt_pkg::ACT_G) begin
                  if (req_chan.code <= gcmt_pkg::G_ARC_CCW) begin
                     flags_in = 3'b001;
                     sfs = feed_ff;
                     // place each axis, first value taken as base
                     for (int ax = 0; ax < 3; ax++) begin
                        if (req_chan.present[ax]) begin
                           seen_in[ax] = 1'b1;
                           base = seen_ff[ax] ? pos_ff[ax] : vin[ax];
                           psum = {vin[ax][31], vin[ax]} + {base[31], base};
                           pos_in[ax] = rel_ff ? gcmt_pkg::sat32(psum) : vin[ax];
                        end
                        diff = {pos_ff[ax][31], pos_ff[ax]} - {pos_in[ax][31], pos_in[ax]};
                        mag_in[ax] = diff[32] ? 32'(-diff) : diff[31:0];
                     end
                     if (req_chan.present[4]) begin
                        feed_in = req_chan.val_f;
                        if ($signed(req_chan.val_f) < $signed(sfs)) begin
                           sfs = req_chan.val_f;
                        end
                     end
                     if (req_chan.present[3]) begin
                        delta = rel_ff ? {req_chan.val_e[31], req_chan.val_e}
                                       : {req_chan.val_e[31], req_chan.val_e}
                                         - {epos_ff[31], epos_ff};
                        sd = {req_chan.val_e[31], req_chan.val_e} + {epos_ff[31], epos_ff};
                        epos_in = rel_ff ? gcmt_pkg::sat32(sd) : req_chan.val_e;
                        if (!delta[32] && (delta != '0)) begin
                           flags_in = 3'b011;
                           esum = {1'b0, ext_sum_ff} + {17'd0, delta[31:0]};
                           ext_sum_in = esum[48] ? gcmt_pkg::MAX48 : esum[47:0];
                           if (lez_ff != pos_in[2]) begin
                              lez_in  = pos_in[2];
                              newl_in = 1'b1;
                           end
                        end else if (delta[32]) begin
                           flags_in = 3'b111;
                           if ($signed(sfs) > $signed(rmax_ff)) begin
                              rmax_in = sfs;
                           end
                        end
                     end
                     if ($signed(sfs) > 0) begin
                        sf_in    = sfs[30:0];
                        cnt_in   = '0;
                        acc_in   = '0;
                        state_in = gcmt_pkg::ST_SQUARE;
                     end
                  end else if (req_chan.code == gcmt_pkg::G_ABSOLUTE) begin
                     rel_in = 1'b0;
                  end else if (req_chan.code == gcmt_pkg::G_RELATIVE) begin
                     rel_in = 1'b1;
                  end else if (req_chan.code == gcmt_pkg::G_SET_ORIGIN) begin
                     for (int ax = 0; ax < 3; ax++) begin
                        if (req_chan.present[ax]) begin
                           seen_in[ax] = 1'b1;
                           pos_in[ax]  = vin[ax];
                        end
                     end
                     if (req_chan.present[3]) begin
                        epos_in = req_chan.val_e;
                     end
                  end
               end else if (req_chan.action != gcmt_pkg::ACT_M) begin
                  stat_in = 1'b1;
               end
            end
         end

         // square one delta per cycle, accumulate the previous product
         gcmt_pkg::ST_SQUARE: begin
            case (cnt_ff[1:0])
               2'd0:    msel = mag_ff[0];
               2'd1:    msel = mag_ff[1];
               default: msel = mag_ff[2];
            endcase
            prod_in = msel * msel;
            if (cnt_ff != '0) begin
               acc_in = acc_ff + {2'b00, prod_ff};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd3) begin
               sq_in    = {2'b00, acc_in};
               rrem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = gcmt_pkg::ST_ROOT;
            end
         end

         // one root bit per cycle, top bit pair first
         gcmt_pkg::ST_ROOT: begin
            rshift = {rrem_ff[33:0], sq_ff[gcmt_pkg::SUM_W+1 -: 2]};
            rtest  = {root_ff, 2'b01};
            sq_in  = {sq_ff[gcmt_pkg::SUM_W-1:0], 2'b00};
            if (rshift >= rtest) begin
               rrem_in = {1'b0, rshift - rtest};
               root_in = {root_ff[gcmt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rrem_in = {1'b0, rshift};
               root_in = {root_ff[gcmt_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(gcmt_pkg::ROOT_W - 1)) begin
               num_in   = {root_in, 22'd0} - {4'd0, root_in, 18'd0};
               dist_in  = (root_in > {3'd0, gcmt_pkg::MAX31}) ? gcmt_pkg::MAX31
                                                               : root_in[30:0];
               drem_in  = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = gcmt_pkg::ST_DIVIDE;
            end
         end

         // restoring division, one quotient bit per cycle
         gcmt_pkg::ST_DIVIDE: begin
            dshift = {drem_ff, num_ff[gcmt_pkg::NUM_W-1]};
            num_in = {num_ff[gcmt_pkg::NUM_W-2:0], 1'b0};
            if (dshift >= {1'b0, sf_ff}) begin
               dshift  = dshift - {1'b0, sf_ff};
               quo_in  = {quo_ff[gcmt_pkg::NUM_W-2:0], 1'b1};
            end else begin
               quo_in  = {quo_ff[gcmt_pkg::NUM_W-2:0], 1'b0};
            end
            drem_in = dshift[30:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'(gcmt_pkg::NUM_W - 1)) begin
               tsum = {9'd0, time_sum_ff} + {1'b0, quo_in};
               time_sum_in = (tsum[56:48] != '0) ? gcmt_pkg::MAX48 : tsum[47:0];
               state_in = gcmt_pkg::ST_FINISH;
            end
         end

         // hand the item to the output register once it is free
         gcmt_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               o_pos_in[0]  = pos_ff[0];
               o_pos_in[1]  = pos_ff[1];
               o_pos_in[2]  = pos_ff[2];
               o_pos_in[3]  = epos_ff;
               o_feed_in    = feed_ff;
               o_rmax_in    = rmax_ff;
               o_dist_in    = dist_ff;
               o_flags_in   = flags_ff;
               o_newl_in    = newl_ff;
               o_stat_in    = stat_ff;
               o_time_in    = time_sum_ff;
               o_ext_in     = ext_sum_ff;
               state_in     = gcmt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gcmt_pkg::ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcmt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '{default: '0};
         epos_ff      <= '0;
         feed_ff      <= '0;
         lez_ff       <= '0;
         rmax_ff      <= '0;
         rel_ff       <= 1'b0;
         seen_ff      <= '0;
         time_sum_ff  <= '0;
         ext_sum_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         epos_ff      <= epos_in;
         feed_ff      <= feed_in;
         lez_ff       <= lez_in;
         rmax_ff      <= rmax_in;
         rel_ff       <= rel_in;
         seen_ff      <= seen_in;
         time_sum_ff  <= time_sum_in;
         ext_sum_ff   <= ext_sum_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      sf_ff      <= sf_in;
      flags_ff   <= flags_in;
      newl_ff    <= newl_in;
      stat_ff    <= stat_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      sq_ff      <= sq_in;
      rrem_ff    <= rrem_in;
      root_ff    <= root_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      drem_ff    <= drem_in;
      dist_ff    <= dist_in;
      o_pos_ff   <= o_pos_in;
      o_feed_ff  <= o_feed_in;
      o_rmax_ff  <= o_rmax_in;
      o_dist_ff  <= o_dist_in;
      o_flags_ff <= o_flags_in;
      o_newl_ff  <= o_newl_in;
      o_stat_ff  <= o_stat_in;
      o_time_ff  <= o_time_in;
      o_ext_ff   <= o_ext_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.pos_x            = o_pos_ff[0];
   assign rsp_chan.pos_y            = o_pos_ff[1];
   assign rsp_chan.pos_z            = o_pos_ff[2];
   assign rsp_chan.pos_e            = o_pos_ff[3];
   assign rsp_chan.feed             = o_feed_ff;
   assign rsp_chan.move_distance    = o_dist_ff;
   assign rsp_chan.move_flags       = o_flags_ff;
   assign rsp_chan.new_layer        = o_newl_ff;
   assign rsp_chan.total_time       = o_time_ff;
   assign rsp_chan.total_extruded   = o_ext_ff;
   assign rsp_chan.max_retract_feed = o_rmax_ff;
   assign rsp_chan.status           = o_stat_ff;

   // a result without the move flag carries no distance or marks
   `ASSERT_SAME(a_nomove_clean, rsp_valid_ff && !o_flags_ff[0], o_dist_ff == '0 && !o_newl_ff)
   // running time total never falls
   `ASSERT_NEXT(a_time_mono, 1'b1, time_sum_ff >= $past(time_sum_ff))
   // an error result changes no flags
   `ASSERT_SAME(a_err_noflags, rsp_valid_ff && o_stat_ff, o_flags_ff == '0)

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the G-code motion state tracker: a queue of commands
// feeds a clocked driver, a clocked monitor compares each result with a
// behavioural copy of the tracker, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] ACT_OTHER = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic [9:0] G_RAPID = 10'd0;
   localparam logic [4:0] HAS_X = 5'b00001;
   localparam logic [4:0] HAS_Y = 5'b00010;
   localparam logic [4:0] HAS_Z = 5'b00100;
   localparam logic [4:0] HAS_E = 5'b01000;
   localparam logic [4:0] HAS_F = 5'b10000;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  code;
      logic [4:0]  present;
      logic [31:0] val_x;
      logic [31:0] val_y;
      logic [31:0] val_z;
      logic [31:0] val_e;
      logic [31:0] val_f;
   } command_type;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] pos_e;
      logic [31:0] feed;
      logic [30:0] move_distance;
      logic [2:0]  move_flags;
      logic        new_layer;
      logic [47:0] total_time;
      logic [47:0] total_extruded;
      logic [31:0] max_retract_feed;
      logic        status;
   } machine_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcmt_req_if req_chan ();
   gcmt_rsp_if rsp_chan ();

   gcode_motion_state_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tracker state mirrored by the bench
   logic signed [31:0] axis_pos [3];
   logic signed [31:0] ext_pos;
   logic signed [31:0] cur_feed;
   logic               rel_mode;
   logic [2:0]         seen_axes;
   logic signed [31:0] layer_z;
   logic [47:0]        time_total;
   logic [47:0]        extruded_total;
   logic signed [31:0] retract_feed_peak;

   command_type       pending_cmds [$];
   machine_state_type expected_states [$];
   int  send_idle_pct = 33;
   int  recv_idle_pct = 84;
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;

   function automatic logic [31:0] place_axis(logic signed [31:0] val, logic signed [31:0] cur);
      logic signed [32:0] s;
      s = {val[31], val} + {cur[31], cur};
      if (!rel_mode) return val;
      if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -33'sd2147483648) return 32'h8000_0000;
      return s[31:0];
   endfunction

   function automatic logic [47:0] add_sat48(logic [47:0] a, logic [63:0] b);
      logic [64:0] s;
      s = a + b;
      return (s > 65'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
   endfunction

   function automatic logic [63:0] int_root(logic [67:0] radicand);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [63:0] root;
      rem = '0;
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | radicand[2*i +: 2];
         trial = {root, 2'b01};
         root = root << 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root[0] = 1'b1;
         end
      end
      return root;
   endfunction

   // Predict the state after one command and advance the mirror
   function automatic machine_state_type track_command(command_type c);
      machine_state_type r;
      logic signed [31:0] start_pos [3];
      logic signed [31:0] start_feed;
      logic signed [32:0] ext_delta;
      logic signed [33:0] d;
      logic [65:0] sq_sum;
      logic [63:0] len;
      logic [127:0] num;
      int order [3];
      int ax;
      order = '{2, 0, 1};
      r = '0;
      if (c.action == gcmt_pkg::ACT_G) begin
         if (c.code <= gcmt_pkg::G_ARC_CCW) begin
            start_pos = axis_pos;
            start_feed = cur_feed;
            r.move_flags[0] = 1'b1;
            for (int i = 0; i < 3; i++) begin
               ax = order[i];
               if (c.present[ax]) begin
                  if (!seen_axes[ax]) begin
                     seen_axes[ax] = 1'b1;
                     axis_pos[ax] = (ax == 0) ? c.val_x : (ax == 1) ? c.val_y : c.val_z;
                  end
                  axis_pos[ax] = place_axis((ax == 0) ? c.val_x : (ax == 1) ? c.val_y : c.val_z,
                                            axis_pos[ax]);
               end
            end
            if (c.present[4]) begin
               cur_feed = c.val_f;
               if ($signed(c.val_f) < start_feed) start_feed = c.val_f;
            end
            if (c.present[3]) begin
               ext_delta = rel_mode ? {c.val_e[31], c.val_e}
                                    : {c.val_e[31], c.val_e} - {ext_pos[31], ext_pos};
               ext_pos = place_axis(c.val_e, ext_pos);
               if (ext_delta > 0) begin
                  r.move_flags[1] = 1'b1;
                  extruded_total = add_sat48(extruded_total, 64'(ext_delta));
                  if (layer_z != axis_pos[2]) begin
                     layer_z = axis_pos[2];
                     r.new_layer = 1'b1;
                  end
               end else if (ext_delta < 0) begin
                  r.move_flags[2:1] = 2'b11;
                  if (start_feed > retract_feed_peak) retract_feed_peak = start_feed;
               end
            end
            if (start_feed > 0) begin
               sq_sum = '0;
               for (int i = 0; i < 3; i++) begin
                  d = {{2{start_pos[i][31]}}, start_pos[i]} - {{2{axis_pos[i][31]}}, axis_pos[i]};
                  if (d < 0) d = -d;
                  sq_sum = sq_sum + 66'(d[32:0]) * 66'(d[32:0]);
               end
               len = int_root({2'b00, sq_sum});
               num = 128'(len) * 128'd60 * 128'd65536 / 128'(start_feed);
               time_total = add_sat48(time_total,
                                      (num > 128'hFFFF_FFFF_FFFF_FFFF) ? '1 : num[63:0]);
               r.move_distance = (len > 64'h7FFF_FFFF) ? gcmt_pkg::MAX31 : len[30:0];
            end
         end else if (c.code == gcmt_pkg::G_ABSOLUTE) begin
            rel_mode = 1'b0;
         end else if (c.code == gcmt_pkg::G_RELATIVE) begin
            rel_mode = 1'b1;
         end else if (c.code == gcmt_pkg::G_SET_ORIGIN) begin
            if (c.present[0]) begin seen_axes[0] = 1'b1; axis_pos[0] = c.val_x; end
            if (c.present[1]) begin seen_axes[1] = 1'b1; axis_pos[1] = c.val_y; end
            if (c.present[2]) begin seen_axes[2] = 1'b1; axis_pos[2] = c.val_z; end
            if (c.present[3]) ext_pos = c.val_e;
         end
      end else if (c.action != gcmt_pkg::ACT_M) begin
         r.status = 1'b1;
      end
      r.pos_x = axis_pos[0];
      r.pos_y = axis_pos[1];
      r.pos_z = axis_pos[2];
      r.pos_e = ext_pos;
      r.feed = cur_feed;
      r.total_time = time_total;
      r.total_extruded = extruded_total;
      r.max_retract_feed = retract_feed_peak;
      return r;
   endfunction

   function automatic command_type make_cmd(logic [1:0] a, logic [9:0] k, logic [4:0] p,
                                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            logic [31:0] e, logic [31:0] f);
      command_type c;
      c = '{a, k, p, x, y, z, e, f};
      return c;
   endfunction

   // Mostly small, realistic coordinates; occasionally anything at all
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      endcase
   endfunction

   function automatic command_type rand_cmd();
      command_type c;
      int pick;
      c.val_x = rand_coord();
      c.val_y = rand_coord();
      c.val_z = rand_coord();
      c.val_e = rand_coord();
      c.val_f = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 6000 << 16);
      c.present = 5'($urandom);
      c.action = gcmt_pkg::ACT_G;
      pick = $urandom_range(0, 99);
      if (pick < 70) c.code = 10'($urandom_range(0, 3));
      else if (pick < 78) c.code = gcmt_pkg::G_ABSOLUTE;
      else if (pick < 84) c.code = gcmt_pkg::G_RELATIVE;
      else if (pick < 90) c.code = gcmt_pkg::G_SET_ORIGIN;
      else if (pick < 94) c.code = 10'($urandom);
      else if (pick < 97) begin c.action = gcmt_pkg::ACT_M; c.code = 10'($urandom); end
      else begin
         c.action = 2'($urandom_range(ACT_OTHER, ACT_SPARE));
         c.code = 10'($urandom);
      end
      return c;
   endfunction

   // Driver: present the next queued item, advance on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) expected_states.push_back(track_command(pending_cmds.pop_front()));
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            {req_chan.action, req_chan.code, req_chan.present, req_chan.val_x,
             req_chan.val_y, req_chan.val_z, req_chan.val_e, req_chan.val_f}
               <= pending_cmds[0];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      machine_state_type got;
      machine_state_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.pos_z, rsp_chan.pos_e,
                    rsp_chan.feed, rsp_chan.move_distance, rsp_chan.move_flags,
                    rsp_chan.new_layer, rsp_chan.total_time, rsp_chan.total_extruded,
                    rsp_chan.max_retract_feed, rsp_chan.status};
            if (expected_states.size() == 0) begin
               mismatches++;
               $display("%0t unexpected result: expected none, actual %h", $realtime, got);
            end else begin
               want = expected_states.pop_front();
               if (got !== want) begin
                  mismatches++;
                  $display("%0t result mismatch: expected %p", $realtime, want);
                  $display("%0t                    actual %p", $realtime, got);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || stimulus_done) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      command_type c;
      req_chan.valid = 1'b0;
      req_chan.action = gcmt_pkg::ACT_G;
      req_chan.code = '0;
      req_chan.present = '0;
      req_chan.val_x = '0;
      req_chan.val_y = '0;
      req_chan.val_z = '0;
      req_chan.val_e = '0;
      req_chan.val_f = '0;
      rsp_chan.ready = 1'b0;
      axis_pos = '{0, 0, 0};
      ext_pos = 0; cur_feed = 0; rel_mode = 0; seen_axes = 0; layer_z = 0;
      time_total = 0; extruded_total = 0; retract_feed_peak = 0;

      // Directed: moves with no feed, first values, extremes, saturation, all handled codes
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, G_RAPID, HAS_X | HAS_Y, 32'd65536,
                                      32'd131072, 0, 0, 0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_F, 0, 0, 0, 0,
                                      32'h7FFF_FFFF));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_X | HAS_Y | HAS_Z | HAS_E,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd65536, 0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_X | HAS_Y | HAS_E,
                                      32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd2, HAS_F | HAS_X, 32'd0, 0, 0, 0,
                                      32'd1));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd3, HAS_X | HAS_Y | HAS_Z,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, gcmt_pkg::G_RELATIVE, 0, 0, 0, 0, 0,
                                      0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_X | HAS_E, 32'h7FFF_FFFF,
                                      0, 0, 32'h7FFF_FFFF, 0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_E, 0, 0, 0, 32'h7FFF_FFFF,
                                      0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_E | HAS_F, 0, 0, 0,
                                      32'h8000_0000, 32'h8000_0000));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, gcmt_pkg::G_SET_ORIGIN, 5'b11111,
                                      32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                      32'hFFFF_0000, 32'd5));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, gcmt_pkg::G_ABSOLUTE, 0, 0, 0, 0, 0,
                                      0));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1, 5'b11111, 32'd0, 0, 0,
                                      32'd65536, 32'd1));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, 10'd1023, 5'b11111, '1, '1, '1, '1,
                                      '1));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_M, 10'd1023, 5'b11111, '1, '1, '1, '1,
                                      '1));
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_M, 10'd0, 0, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(ACT_OTHER, 10'd0, 5'b11111, 1, 1, 1, 1, 1));
      pending_cmds.push_back(make_cmd(ACT_SPARE, 10'd1023, 0, 0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Random commands over three idling phases, draining between them
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < 650; n++) pending_cmds.push_back(rand_cmd());
         wait (pending_cmds.size() == 0 && expected_states.size() == 0);
         @(posedge clock);
         if (phase == 0) begin
            send_idle_pct = 84;
            recv_idle_pct = 33;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end

      // Long totals: repeated huge moves at the lowest feed to saturate the time sum
      pending_cmds.push_back(make_cmd(gcmt_pkg::ACT_G, gcmt_pkg::G_ABSOLUTE, 0, 0, 0, 0, 0,
                                      0));
      for (int n = 0; n < 12; n++) begin
         c = make_cmd(gcmt_pkg::ACT_G, 10'd1, HAS_X | HAS_Y | HAS_Z | HAS_E | HAS_F,
                      n[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                      n[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                      n[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                      n[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd1);
         pending_cmds.push_back(c);
      end
      wait (pending_cmds.size() == 0 && expected_states.size() == 0);
      stimulus_done = 1'b1;
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
